### sv/r3fp_pkg.sv
// ----------------------------------------------------------------------------
// r3fp_pkg: shared types and constants for the radix-3 Feistel permutation
// Field widths, digit geometry, reciprocal constants for the constant
// dividers, and the per-round digit weight tables.
// ----------------------------------------------------------------------------
`default_nettype none

package r3fp_pkg;

  localparam int FIELD_W     = 13;
  localparam int HALF_DIGITS = 8;
  localparam int RADIX       = 3;
  localparam int ROUND_COUNT = 4;

  // modulus of one half: RADIX^HALF_DIGITS, must stay below 2^FIELD_W
  localparam int MODULUS = RADIX ** HALF_DIGITS;

  localparam int DIGIT_W = $clog2(RADIX);

  // floor(x / RADIX) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2^FIELD_W
  localparam int     DIV_SHIFT   = FIELD_W + $clog2(RADIX);
  localparam longint DIV_RECIP   = ((longint'(1) << DIV_SHIFT) + RADIX - 1) / RADIX;
  localparam int     DIV_RECIP_W = $clog2(DIV_RECIP + 1);

  // floor(x / MODULUS), same construction
  localparam int     MOD_SHIFT   = FIELD_W + $clog2(MODULUS);
  localparam longint MOD_RECIP   = ((longint'(1) << MOD_SHIFT) + MODULUS - 1) / MODULUS;
  localparam int     MOD_RECIP_W = $clog2(MOD_RECIP + 1);

  typedef logic [FIELD_W-1:0] half_t;

  typedef struct packed {
    half_t left_half;
    half_t right_half;
  } in_item_t;

  typedef struct packed {
    half_t out_left;
    half_t out_right;
  } out_item_t;

  typedef struct packed {
    half_t left;
    half_t right;
  } half_pair_t;

  // row[d] = (d * key^pos) mod MODULUS
  typedef logic [RADIX-1:0][FIELD_W-1:0] term_row_t;

  function automatic term_row_t term_row(input int key, input int pos);
    term_row_t row;
    longint    pw;
    pw = 1 % MODULUS;
    for (int i = 0; i < pos; i++) begin
      pw = (pw * key) % MODULUS;
    end
    for (int d = 0; d < RADIX; d++) begin
      row[d] = half_t'((d * pw) % MODULUS);
    end
    return row;
  endfunction

endpackage

`default_nettype wire

### sv/r3fp_reduce.sv
// ----------------------------------------------------------------------------
// r3fp_reduce: input reduction mod RADIX^HALF_DIGITS
// Two stages: reciprocal multiply for the quotient, then multiply back and
// subtract for the remainder. Both halves in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module r3fp_reduce (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  r3fp_pkg::half_pair_t  in_pair,
  output logic                  out_valid,
  output r3fp_pkg::half_pair_t  out_pair
);

  localparam int PROD_W = r3fp_pkg::FIELD_W + r3fp_pkg::MOD_RECIP_W;
  typedef logic [PROD_W-1:0] prod_t;

  prod_t                prod_left;
  prod_t                prod_right;
  r3fp_pkg::half_t      quot_left_next;
  r3fp_pkg::half_t      quot_right_next;

  logic                 valid_q;
  r3fp_pkg::half_pair_t pair_q;
  r3fp_pkg::half_t      quot_left;
  r3fp_pkg::half_t      quot_right;

  assign prod_left       = prod_t'(in_pair.left) * prod_t'(r3fp_pkg::MOD_RECIP);
  assign prod_right      = prod_t'(in_pair.right) * prod_t'(r3fp_pkg::MOD_RECIP);
  assign quot_left_next  = r3fp_pkg::half_t'(prod_left >> r3fp_pkg::MOD_SHIFT);
  assign quot_right_next = r3fp_pkg::half_t'(prod_right >> r3fp_pkg::MOD_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_q     <= in_pair;
      quot_left  <= quot_left_next;
      quot_right <= quot_right_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_q;
    end
  end

  // remainder is below the modulus, so the low bits of the difference suffice
  always_ff @(posedge clk) begin
    if (en) begin
      out_pair.left  <= pair_q.left
                        - r3fp_pkg::half_t'(quot_left * r3fp_pkg::half_t'(r3fp_pkg::MODULUS));
      out_pair.right <= pair_q.right
                        - r3fp_pkg::half_t'(quot_right * r3fp_pkg::half_t'(r3fp_pkg::MODULUS));
    end
  end

endmodule

`default_nettype wire

### sv/r3fp_round.sv
// ----------------------------------------------------------------------------
// r3fp_round: one Feistel round with a fixed key
// One stage per digit of the right half (least significant first), each
// peeling a digit and adding its weighted term mod M, then one stage for the
// XOR, reduction and swap.
// ----------------------------------------------------------------------------
`default_nettype none

module r3fp_round #(
  parameter int KEY = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  r3fp_pkg::half_pair_t  in_pair,
  output logic                  out_valid,
  output r3fp_pkg::half_pair_t  out_pair
);

  localparam int N      = r3fp_pkg::HALF_DIGITS;
  localparam int PROD_W = r3fp_pkg::FIELD_W + r3fp_pkg::DIV_RECIP_W;
  localparam int SUM_W  = r3fp_pkg::FIELD_W + 1;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SUM_W-1:0]  sum_t;

  logic            tap_valid [N+1];
  r3fp_pkg::half_t tap_left  [N+1];
  r3fp_pkg::half_t tap_right [N+1];
  r3fp_pkg::half_t tap_x     [N+1];
  r3fp_pkg::half_t tap_acc   [N+1];

  assign tap_valid[0] = in_valid;
  assign tap_left[0]  = in_pair.left;
  assign tap_right[0] = in_pair.right;
  assign tap_x[0]     = in_pair.right;
  assign tap_acc[0]   = '0;

  for (genvar s = 0; s < N; s++) begin : g_digit
    // digit peeled here sits at position N-s counted from the top
    localparam r3fp_pkg::term_row_t TERMS = r3fp_pkg::term_row(KEY, N - s);

    prod_t                        prod;
    r3fp_pkg::half_t              quot;
    r3fp_pkg::half_t              rem_full;
    logic [r3fp_pkg::DIGIT_W-1:0] digit;
    sum_t                         sum;
    r3fp_pkg::half_t              acc_next;

    logic                         valid;
    r3fp_pkg::half_t              left;
    r3fp_pkg::half_t              right;
    r3fp_pkg::half_t              x;
    r3fp_pkg::half_t              acc;

    assign prod     = prod_t'(tap_x[s]) * prod_t'(r3fp_pkg::DIV_RECIP);
    assign quot     = r3fp_pkg::half_t'(prod >> r3fp_pkg::DIV_SHIFT);
    assign rem_full = tap_x[s]
                      - r3fp_pkg::half_t'(quot * r3fp_pkg::half_t'(r3fp_pkg::RADIX));
    assign digit    = rem_full[r3fp_pkg::DIGIT_W-1:0];
    assign sum      = sum_t'(tap_acc[s]) + sum_t'(TERMS[digit]);
    assign acc_next = (sum >= sum_t'(r3fp_pkg::MODULUS))
                      ? r3fp_pkg::half_t'(sum - sum_t'(r3fp_pkg::MODULUS))
                      : r3fp_pkg::half_t'(sum);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid <= 1'b0;
      end else if (en) begin
        valid <= tap_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        left  <= tap_left[s];
        right <= tap_right[s];
        x     <= quot;
        acc   <= acc_next;
      end
    end

    assign tap_valid[s+1] = valid;
    assign tap_left[s+1]  = left;
    assign tap_right[s+1] = right;
    assign tap_x[s+1]     = x;
    assign tap_acc[s+1]   = acc;
  end

  // left and F are both below M, so the XOR stays below 2M
  r3fp_pkg::half_t mix;
  r3fp_pkg::half_t right_next;

  assign mix        = tap_left[N] ^ tap_acc[N];
  assign right_next = (mix >= r3fp_pkg::half_t'(r3fp_pkg::MODULUS))
                      ? mix - r3fp_pkg::half_t'(r3fp_pkg::MODULUS)
                      : mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tap_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pair.left  <= tap_right[N];
      out_pair.right <= right_next;
    end
  end

endmodule

`default_nettype wire

### sv/r3fp_out_buf.sv
// ----------------------------------------------------------------------------
// r3fp_out_buf: two-entry output buffer
// Registered ready: it drops only when both entries hold an item, which
// keeps the downstream ready off the pipeline's enable path.
// ----------------------------------------------------------------------------
`default_nettype none

module r3fp_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  r3fp_pkg::out_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output r3fp_pkg::out_item_t  out_item
);

  logic                head_valid;
  logic                tail_valid;
  r3fp_pkg::out_item_t head;
  r3fp_pkg::out_item_t tail;
  logic                push;
  logic                pop;

  assign in_ready  = !tail_valid;
  assign out_valid = head_valid;
  assign out_item  = head;
  assign push      = in_valid && in_ready;
  assign pop       = head_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (head_valid) begin
            tail_valid <= 1'b1;
          end else begin
            head_valid <= 1'b1;
          end
        end
        2'b01: begin
          if (tail_valid) begin
            tail_valid <= 1'b0;
          end else begin
            head_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // push implies the tail is free, so a push with a pop refills the head
  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (head_valid) begin
        tail <= in_item;
      end else begin
        head <= in_item;
      end
    end else if (pop && !push && tail_valid) begin
      head <= tail;
    end else if (push && pop) begin
      head <= in_item;
    end
  end

endmodule

`default_nettype wire

### sv/radix3_feistel_permutation_core.sv
// ----------------------------------------------------------------------------
// radix3_feistel_permutation_core: four-round radix-3 Feistel permutation
// Reduces both halves mod 3^8, runs the unrolled rounds with keys 1..ROUND_COUNT and
// emits the final right half followed by the final left half.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   input   | in_valid / in_ready  | in_item  : left_half, right_half
//   output  | out_valid/ out_ready | out_item : out_left, out_right
//
// One item per cycle while the output buffer's ready is high; the pipeline
// into the output buffer has one stage per digit per round plus the XOR
// stage, and the two-stage input reduction.
// Reset (rst, synchronous) clears the stage valid bits and the buffer.
// The whole pipeline advances on one enable: the output buffer's registered
// ready. It drops only when both buffer entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module radix3_feistel_permutation_core #(
  parameter int ROUND_COUNT = r3fp_pkg::ROUND_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  r3fp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output r3fp_pkg::out_item_t  out_item
);

  logic                 en;
  r3fp_pkg::half_pair_t in_pair;
  logic                 chain_valid [ROUND_COUNT+1];
  r3fp_pkg::half_pair_t chain_pair  [ROUND_COUNT+1];
  r3fp_pkg::out_item_t  fin_item;

  assign in_ready      = en;
  assign in_pair.left  = in_item.left_half;
  assign in_pair.right = in_item.right_half;

  r3fp_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_pair   (in_pair),
    .out_valid (chain_valid[0]),
    .out_pair  (chain_pair[0])
  );

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    r3fp_round #(
      .KEY (r + 1)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[r]),
      .in_pair   (chain_pair[r]),
      .out_valid (chain_valid[r+1]),
      .out_pair  (chain_pair[r+1])
    );
  end

  // output order: final right half first
  assign fin_item.out_left  = chain_pair[ROUND_COUNT].right;
  assign fin_item.out_right = chain_pair[ROUND_COUNT].left;

  r3fp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[ROUND_COUNT]),
    .in_ready  (en),
    .in_item   (fin_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // stall only happens with a full buffer, so a result must be waiting
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a pop from a full buffer must reopen the input next cycle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !in_ready |=> in_ready)
    else $error("input still stalled after buffer drained");

  // both result halves are reduced mod M
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.out_left < r3fp_pkg::half_t'(r3fp_pkg::MODULUS)) &&
                  (out_item.out_right < r3fp_pkg::half_t'(r3fp_pkg::MODULUS)))
    else $error("result half not reduced");

endmodule

`default_nettype wire
